// ----- rtl/slx_pkg.sv -----
// Shared types, codes, character constants and decode functions of the byte-stream lexer.
package slx_pkg;

   typedef enum logic [3:0] {
      ST_BEGIN,
      ST_COMMENT,
      ST_AT,
      ST_EQ,
      ST_NOT,
      ST_LT,
      ST_GT,
      ST_INT,
      ST_DEC,
      ST_WORD,
      ST_STR,
      ST_ESC
   } lex_state_type;

   typedef enum logic [1:0] {
      KIND_VALUE,
      KIND_TOKEN,
      KIND_ERROR,
      KIND_ABANDON
   } kind_type;

   localparam logic [5:0] CODE_NONE     = 6'd0;
   localparam logic [5:0] TOK_COLON     = 6'd0;
   localparam logic [5:0] TOK_COMMA     = 6'd1;
   localparam logic [5:0] TOK_DOT       = 6'd2;
   localparam logic [5:0] TOK_LPAREN    = 6'd3;
   localparam logic [5:0] TOK_RPAREN    = 6'd4;
   localparam logic [5:0] TOK_LBRACKET  = 6'd5;
   localparam logic [5:0] TOK_RBRACKET  = 6'd6;
   localparam logic [5:0] TOK_LBRACE    = 6'd7;
   localparam logic [5:0] TOK_RBRACE    = 6'd8;
   localparam logic [5:0] TOK_PLUS      = 6'd9;
   localparam logic [5:0] TOK_MINUS     = 6'd10;
   localparam logic [5:0] TOK_STAR      = 6'd11;
   localparam logic [5:0] TOK_SLASH     = 6'd12;
   localparam logic [5:0] TOK_PERCENT   = 6'd13;
   localparam logic [5:0] TOK_AMP       = 6'd14;
   localparam logic [5:0] TOK_PIPE      = 6'd15;
   localparam logic [5:0] TOK_CARET     = 6'd16;
   localparam logic [5:0] TOK_TILDE     = 6'd17;
   localparam logic [5:0] TOK_AT        = 6'd18;
   localparam logic [5:0] TOK_ATAT      = 6'd19;
   localparam logic [5:0] TOK_ARROW     = 6'd20;
   localparam logic [5:0] TOK_EQ        = 6'd21;
   localparam logic [5:0] TOK_NOT       = 6'd22;
   localparam logic [5:0] TOK_NE        = 6'd23;
   localparam logic [5:0] TOK_LE        = 6'd24;
   localparam logic [5:0] TOK_SHL       = 6'd25;
   localparam logic [5:0] TOK_LT        = 6'd26;
   localparam logic [5:0] TOK_GE        = 6'd27;
   localparam logic [5:0] TOK_SHR       = 6'd28;
   localparam logic [5:0] TOK_GT        = 6'd29;
   localparam logic [5:0] TOK_END       = 6'd30;
   localparam logic [5:0] TOK_INT       = 6'd31;
   localparam logic [5:0] TOK_DEC       = 6'd32;
   localparam logic [5:0] TOK_STR       = 6'd33;
   localparam logic [5:0] TOK_WORD      = 6'd34;

   localparam logic [7:0] CH_NUL      = 8'h00;
   localparam logic [7:0] CH_NL       = 8'h0A;
   localparam logic [7:0] CH_BANG     = 8'h21;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_HASH     = 8'h23;
   localparam logic [7:0] CH_DOLLAR   = 8'h24;
   localparam logic [7:0] CH_PERCENT  = 8'h25;
   localparam logic [7:0] CH_AMP      = 8'h26;
   localparam logic [7:0] CH_LPAREN   = 8'h28;
   localparam logic [7:0] CH_RPAREN   = 8'h29;
   localparam logic [7:0] CH_STAR     = 8'h2A;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_DOT      = 8'h2E;
   localparam logic [7:0] CH_SLASH    = 8'h2F;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_LT       = 8'h3C;
   localparam logic [7:0] CH_EQ       = 8'h3D;
   localparam logic [7:0] CH_GT       = 8'h3E;
   localparam logic [7:0] CH_AT       = 8'h40;
   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_BSL      = 8'h5C;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_CARET    = 8'h5E;
   localparam logic [7:0] CH_UNDER    = 8'h5F;
   localparam logic [7:0] CH_LOW_A    = 8'h61;
   localparam logic [7:0] CH_LOW_B    = 8'h62;
   localparam logic [7:0] CH_LOW_F    = 8'h66;
   localparam logic [7:0] CH_LOW_N    = 8'h6E;
   localparam logic [7:0] CH_LOW_R    = 8'h72;
   localparam logic [7:0] CH_LOW_T    = 8'h74;
   localparam logic [7:0] CH_LOW_Z    = 8'h7A;
   localparam logic [7:0] CH_LBRACE   = 8'h7B;
   localparam logic [7:0] CH_PIPE     = 8'h7C;
   localparam logic [7:0] CH_RBRACE   = 8'h7D;
   localparam logic [7:0] CH_TILDE    = 8'h7E;

   localparam logic [7:0] ESC_BEL = 8'd7;
   localparam logic [7:0] ESC_BS  = 8'd8;
   localparam logic [7:0] ESC_TAB = 8'd9;
   localparam logic [7:0] ESC_LF  = 8'd10;
   localparam logic [7:0] ESC_FF  = 8'd12;
   localparam logic [7:0] ESC_CR  = 8'd13;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      kind_type   kind;
      logic [5:0] token_code;
      logic [7:0] value_byte;
   } result_type;

   typedef struct packed {
      logic       two;
      result_type first;
      result_type second;
   } bundle_type;

   typedef struct packed {
      logic       valid;
      bundle_type bundle;
   } entry_type;

   typedef struct packed {
      lex_state_type next_state;
      logic          emit;
      logic          pending;
      result_type    res;
   } idle_type;

   function automatic result_type make_result(kind_type k, logic [5:0] code, logic [7:0] b);
      result_type r;
      r.kind       = k;
      r.token_code = code;
      r.value_byte = b;
      return r;
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_letter(logic [7:0] c);
      return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ||
             ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) || (c == CH_UNDER);
   endfunction

   // Handling of one byte from the begin state.
   function automatic idle_type idle_decode(logic [7:0] c);
      idle_type   d;
      logic [5:0] code;
      logic       tok;
      d.next_state = ST_BEGIN;
      d.emit       = 1'b0;
      d.pending    = 1'b0;
      d.res        = make_result(KIND_VALUE, CODE_NONE, c);
      code         = CODE_NONE;
      tok          = 1'b1;
      unique case (c)
         CH_DOLLAR:   code = TOK_END;
         CH_COLON:    code = TOK_COLON;
         CH_COMMA:    code = TOK_COMMA;
         CH_DOT:      code = TOK_DOT;
         CH_LPAREN:   code = TOK_LPAREN;
         CH_RPAREN:   code = TOK_RPAREN;
         CH_LBRACKET: code = TOK_LBRACKET;
         CH_RBRACKET: code = TOK_RBRACKET;
         CH_LBRACE:   code = TOK_LBRACE;
         CH_RBRACE:   code = TOK_RBRACE;
         CH_PLUS:     code = TOK_PLUS;
         CH_MINUS:    code = TOK_MINUS;
         CH_STAR:     code = TOK_STAR;
         CH_SLASH:    code = TOK_SLASH;
         CH_PERCENT:  code = TOK_PERCENT;
         CH_AMP:      code = TOK_AMP;
         CH_PIPE:     code = TOK_PIPE;
         CH_CARET:    code = TOK_CARET;
         CH_TILDE:    code = TOK_TILDE;
         CH_HASH: begin
            tok          = 1'b0;
            d.next_state = ST_COMMENT;
         end
         CH_AT: begin
            tok          = 1'b0;
            d.next_state = ST_AT;
         end
         CH_QUOTE: begin
            tok          = 1'b0;
            d.next_state = ST_STR;
         end
         CH_EQ: begin
            tok          = 1'b0;
            d.next_state = ST_EQ;
         end
         CH_BANG: begin
            tok          = 1'b0;
            d.next_state = ST_NOT;
         end
         CH_LT: begin
            tok          = 1'b0;
            d.next_state = ST_LT;
         end
         CH_GT: begin
            tok          = 1'b0;
            d.next_state = ST_GT;
         end
         default: begin
            tok = 1'b0;
            if (is_digit(c)) begin
               d.next_state = ST_INT;
               d.emit       = 1'b1;
               d.pending    = 1'b1;
            end else if (is_letter(c)) begin
               d.next_state = ST_WORD;
               d.emit       = 1'b1;
               d.pending    = 1'b1;
            end
         end
      endcase
      if (tok) begin
         d.emit = 1'b1;
         d.res  = make_result(KIND_TOKEN, code, 8'd0);
      end
      return d;
   endfunction

endpackage

// ----- rtl/script_lexer_byte_stream.sv -----
// Byte-stream lexer top level.
// The block accepts one source byte per clock cycle and lexes it in a state machine, so a new
// byte can follow every cycle while the queue is not full. Each byte yields zero, one or two
// results; they travel as one bundle through a four-entry queue to an output stage that sends
// one transaction per cycle while rsp_stall is low, so a byte with two results takes two
// transactions, and a run of such bytes fills the queue and stalls the input. A result passes
// through a queue slot and the output register before it reaches the result channel. rsp_last
// marks the final result of each byte; bytes that give no result produce no transaction.
module script_lexer_byte_stream (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_line_start,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [5:0] rsp_token_code,
   output logic [7:0] rsp_value_byte,
   output logic       rsp_last
);

   slx_pkg::entry_type  push;
   slx_pkg::entry_type  head;
   slx_pkg::result_type result;
   logic                queue_full;
   logic                pop;

   slx_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_in    (req_char_in),
      .req_line_start (req_line_start),
      .queue_full     (queue_full),
      .push           (push)
   );

   slx_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .head  (head)
   );

   slx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (result),
      .rsp_last   (rsp_last)
   );

   assign rsp_kind       = result.kind;
   assign rsp_token_code = result.token_code;
   assign rsp_value_byte = result.value_byte;

endmodule

// ----- rtl/slx_front.sv -----
// Lexer front end: accepts source bytes, runs the lexing state machine and emits result bundles.
module slx_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_in,
   input  logic               req_line_start,
   input  logic               queue_full,
   output slx_pkg::entry_type push
);

   typedef struct packed {
      slx_pkg::lex_state_type state;
      logic                   pending;
      logic                   stopped;
      logic [1:0]             count;
      slx_pkg::result_type    r0;
      slx_pkg::result_type    r1;
   } step_type;

   function automatic step_type put(step_type s, slx_pkg::result_type r);
      step_type t;
      t = s;
      if (t.count == 2'd0) begin
         t.r0 = r;
      end else if (t.count == 2'd1) begin
         t.r1 = r;
      end
      if (t.count != 2'd2) begin
         t.count = t.count + 2'd1;
      end
      return t;
   endfunction

   function automatic step_type put_value(step_type s, logic [7:0] b);
      step_type t;
      t = put(s, slx_pkg::make_result(slx_pkg::KIND_VALUE, slx_pkg::CODE_NONE, b));
      t.pending = 1'b1;
      return t;
   endfunction

   function automatic step_type put_token(step_type s, logic [5:0] code);
      step_type t;
      t = put(s, slx_pkg::make_result(slx_pkg::KIND_TOKEN, code, 8'd0));
      t.pending = 1'b0;
      t.state   = slx_pkg::ST_BEGIN;
      return t;
   endfunction

   function automatic step_type put_error(step_type s);
      step_type t;
      t = put(s, slx_pkg::make_result(slx_pkg::KIND_ERROR, slx_pkg::CODE_NONE, 8'd0));
      t.pending = 1'b0;
      t.state   = slx_pkg::ST_BEGIN;
      t.stopped = 1'b1;
      return t;
   endfunction

   function automatic step_type lex_step(slx_pkg::lex_state_type st, logic pend, logic stop,
                                         logic [7:0] c, logic ls);
      step_type          s;
      slx_pkg::idle_type d;
      logic              redo;
      logic              idle;
      logic [5:0]        rcode;
      s.state   = st;
      s.pending = pend;
      s.stopped = stop;
      s.count   = 2'd0;
      s.r0      = '0;
      s.r1      = '0;
      redo      = 1'b0;
      idle      = 1'b0;
      rcode     = slx_pkg::CODE_NONE;
      if (ls) begin
         if (pend) begin
            s = put(s, slx_pkg::make_result(slx_pkg::KIND_ABANDON, slx_pkg::CODE_NONE, 8'd0));
         end
         s.state   = slx_pkg::ST_BEGIN;
         s.pending = 1'b0;
         s.stopped = 1'b0;
      end
      if (!s.stopped) begin
         if (c == slx_pkg::CH_NUL) begin
            s.stopped = 1'b1;
         end else begin
            unique case (s.state)
               slx_pkg::ST_COMMENT: begin
                  if (c == slx_pkg::CH_NL) begin
                     s.state = slx_pkg::ST_BEGIN;
                  end
               end
               slx_pkg::ST_AT: begin
                  if (c == slx_pkg::CH_AT) begin
                     s = put_token(s, slx_pkg::TOK_ATAT);
                  end else begin
                     redo  = 1'b1;
                     rcode = slx_pkg::TOK_AT;
                  end
               end
               slx_pkg::ST_EQ: begin
                  if (c == slx_pkg::CH_GT) begin
                     s = put_token(s, slx_pkg::TOK_ARROW);
                  end else begin
                     redo  = 1'b1;
                     rcode = slx_pkg::TOK_EQ;
                  end
               end
               slx_pkg::ST_NOT: begin
                  if (c == slx_pkg::CH_EQ) begin
                     s = put_token(s, slx_pkg::TOK_NE);
                  end else begin
                     redo  = 1'b1;
                     rcode = slx_pkg::TOK_NOT;
                  end
               end
               slx_pkg::ST_LT: begin
                  if (c == slx_pkg::CH_EQ) begin
                     s = put_token(s, slx_pkg::TOK_LE);
                  end else if (c == slx_pkg::CH_LT) begin
                     s = put_token(s, slx_pkg::TOK_SHL);
                  end else begin
                     redo  = 1'b1;
                     rcode = slx_pkg::TOK_LT;
                  end
               end
               slx_pkg::ST_GT: begin
                  if (c == slx_pkg::CH_EQ) begin
                     s = put_token(s, slx_pkg::TOK_GE);
                  end else if (c == slx_pkg::CH_GT) begin
                     s = put_token(s, slx_pkg::TOK_SHR);
                  end else begin
                     redo  = 1'b1;
                     rcode = slx_pkg::TOK_GT;
                  end
               end
               slx_pkg::ST_INT: begin
                  if (slx_pkg::is_digit(c)) begin
                     s = put_value(s, c);
                  end else if (c == slx_pkg::CH_DOT) begin
                     s       = put_value(s, c);
                     s.state = slx_pkg::ST_DEC;
                  end else begin
                     redo  = 1'b1;
                     rcode = slx_pkg::TOK_INT;
                  end
               end
               slx_pkg::ST_DEC: begin
                  if (slx_pkg::is_digit(c)) begin
                     s = put_value(s, c);
                  end else begin
                     redo  = 1'b1;
                     rcode = slx_pkg::TOK_DEC;
                  end
               end
               slx_pkg::ST_WORD: begin
                  if (slx_pkg::is_letter(c)) begin
                     s = put_value(s, c);
                  end else begin
                     redo  = 1'b1;
                     rcode = slx_pkg::TOK_WORD;
                  end
               end
               slx_pkg::ST_STR: begin
                  if (c == slx_pkg::CH_NL) begin
                     s = put_error(s);
                  end else if (c == slx_pkg::CH_BSL) begin
                     s.state = slx_pkg::ST_ESC;
                  end else if (c == slx_pkg::CH_QUOTE) begin
                     s = put_token(s, slx_pkg::TOK_STR);
                  end else begin
                     s = put_value(s, c);
                  end
               end
               slx_pkg::ST_ESC: begin
                  s.state = slx_pkg::ST_STR;
                  unique case (c)
                     slx_pkg::CH_NL:    s = put_error(s);
                     slx_pkg::CH_LOW_N: s = put_value(s, slx_pkg::ESC_LF);
                     slx_pkg::CH_BSL:   s = put_value(s, slx_pkg::CH_BSL);
                     slx_pkg::CH_QUOTE: s = put_value(s, slx_pkg::CH_QUOTE);
                     slx_pkg::CH_LOW_A: s = put_value(s, slx_pkg::ESC_BEL);
                     slx_pkg::CH_LOW_B: s = put_value(s, slx_pkg::ESC_BS);
                     slx_pkg::CH_ZERO:  s = put_value(s, slx_pkg::CH_NUL);
                     slx_pkg::CH_LOW_T: s = put_value(s, slx_pkg::ESC_TAB);
                     slx_pkg::CH_LOW_R: s = put_value(s, slx_pkg::ESC_CR);
                     slx_pkg::CH_LOW_F: s = put_value(s, slx_pkg::ESC_FF);
                     default: begin
                        s = put_value(s, slx_pkg::CH_BSL);
                        s = put_value(s, c);
                     end
                  endcase
               end
               default: idle = 1'b1;
            endcase
            if (redo) begin
               s = put_token(s, rcode);
            end
            if (redo || idle) begin
               d       = slx_pkg::idle_decode(c);
               s.state = d.next_state;
               if (d.emit) begin
                  s = put(s, d.res);
               end
               if (d.pending) begin
                  s.pending = 1'b1;
               end
            end
         end
      end
      return s;
   endfunction

   slx_pkg::lex_state_type lex_state_ff;
   slx_pkg::lex_state_type lex_state_in;
   logic                   value_pending_ff;
   logic                   value_pending_in;
   logic                   line_stopped_ff;
   logic                   line_stopped_in;
   logic                   accept;
   step_type               step;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      step = lex_step(lex_state_ff, value_pending_ff, line_stopped_ff,
                      req_char_in, req_line_start);
   end

   always_comb begin
      lex_state_in     = lex_state_ff;
      value_pending_in = value_pending_ff;
      line_stopped_in  = line_stopped_ff;
      if (accept) begin
         lex_state_in     = step.state;
         value_pending_in = step.pending;
         line_stopped_in  = step.stopped;
      end
   end

   always_comb begin
      push.valid         = accept && (step.count != 2'd0);
      push.bundle.two    = (step.count == 2'd2);
      push.bundle.first  = step.r0;
      push.bundle.second = step.r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lex_state_ff     <= slx_pkg::ST_BEGIN;
         value_pending_ff <= 1'b0;
         line_stopped_ff  <= 1'b0;
      end else begin
         lex_state_ff     <= lex_state_in;
         value_pending_ff <= value_pending_in;
         line_stopped_ff  <= line_stopped_in;
      end
   end

endmodule

// ----- rtl/slx_queue.sv -----
// Short queue of result bundles between the lexer front end and the output stage.
module slx_queue (
   input  logic               clock,
   input  logic               reset,
   input  slx_pkg::entry_type push,
   output logic               full,
   input  logic               pop,
   output slx_pkg::entry_type head
);

   slx_pkg::bundle_type                     slots_ff [slx_pkg::QUEUE_DEPTH];
   logic [slx_pkg::QUEUE_PTR_W-1:0]         wr_ptr_ff;
   logic [slx_pkg::QUEUE_PTR_W-1:0]         wr_ptr_in;
   logic [slx_pkg::QUEUE_PTR_W-1:0]         rd_ptr_ff;
   logic [slx_pkg::QUEUE_PTR_W-1:0]         rd_ptr_in;
   logic [slx_pkg::QUEUE_CNT_W-1:0]         count_ff;
   logic [slx_pkg::QUEUE_CNT_W-1:0]         count_in;
   logic                                    do_push;
   logic                                    do_pop;

   localparam logic [slx_pkg::QUEUE_PTR_W-1:0] LastSlot =
      slx_pkg::QUEUE_PTR_W'(slx_pkg::QUEUE_DEPTH - 1);
   localparam logic [slx_pkg::QUEUE_CNT_W-1:0] FullCount =
      slx_pkg::QUEUE_CNT_W'(slx_pkg::QUEUE_DEPTH);

   assign full        = (count_ff == FullCount);
   assign head.valid  = (count_ff != '0);
   assign head.bundle = slots_ff[rd_ptr_ff];
   assign do_push     = push.valid && !full;
   assign do_pop      = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push.bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/slx_back.sv -----
// Output stage: splits result bundles into single transactions on the result channel.
module slx_back (
   input  logic                clock,
   input  logic                reset,
   input  slx_pkg::entry_type  head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output slx_pkg::result_type rsp_result,
   output logic                rsp_last
);

   logic                out_valid_ff;
   logic                out_valid_in;
   slx_pkg::result_type out_ff;
   slx_pkg::result_type out_in;
   logic                out_last_ff;
   logic                out_last_in;
   logic                spare_valid_ff;
   logic                spare_valid_in;
   slx_pkg::result_type spare_ff;
   slx_pkg::result_type spare_in;
   logic                load;

   assign load       = !out_valid_ff || !rsp_stall;
   assign pop        = load && !spare_valid_ff && head.valid;
   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;
   assign rsp_last   = out_last_ff;

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_in         = out_ff;
      out_last_in    = out_last_ff;
      spare_valid_in = spare_valid_ff;
      spare_in       = spare_ff;
      if (load) begin
         if (spare_valid_ff) begin
            out_valid_in   = 1'b1;
            out_in         = spare_ff;
            out_last_in    = 1'b1;
            spare_valid_in = 1'b0;
         end else if (head.valid) begin
            out_valid_in   = 1'b1;
            out_in         = head.bundle.first;
            out_last_in    = !head.bundle.two;
            spare_valid_in = head.bundle.two;
            spare_in       = head.bundle.second;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
      spare_ff    <= spare_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         out_valid_ff   <= out_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the byte-stream lexer: directed lines, then random lines under varied handshake pressure.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      slx_pkg::kind_type kind;
      logic [5:0]        code;
      logic [7:0]        vbyte;
      logic              last;
   } lex_result_type;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_in    = 8'd0;
   logic       req_line_start = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [1:0] rsp_kind;
   logic [5:0] rsp_token_code;
   logic [7:0] rsp_value_byte;
   logic       rsp_last;

   script_lexer_byte_stream uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_in   (req_char_in),
      .req_line_start(req_line_start),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_token_code(rsp_token_code),
      .rsp_value_byte(rsp_value_byte),
      .rsp_last      (rsp_last)
   );

   always #6 clock = ~clock;

   lex_result_type         due_results[$];
   lex_result_type         step_res[2];
   int                     step_count;
   slx_pkg::lex_state_type lx_state   = slx_pkg::ST_BEGIN;
   logic                   lx_pending = 1'b0;
   logic                   lx_stopped = 1'b0;

   logic [8:0]    line_q[$];
   int            send_idle_pct  = 0;
   int            recv_stall_pct = 0;
   int            bytes_sent     = 0;
   int            live_bytes     = 0;
   int            kind_seen[4]   = '{0, 0, 0, 0};
   int            fail_count     = 0;
   int            cycles         = 0;

   function void put(slx_pkg::kind_type k, logic [5:0] code, logic [7:0] b);
      if (step_count < 2) begin
         step_res[step_count] = '{k, code, b, 1'b0};
         step_count++;
      end
   endfunction

   function void put_value(logic [7:0] b);
      put(slx_pkg::KIND_VALUE, slx_pkg::CODE_NONE, b);
      lx_pending = 1'b1;
   endfunction

   function void close_token(logic [5:0] code);
      put(slx_pkg::KIND_TOKEN, code, 8'd0);
      lx_pending = 1'b0;
      lx_state   = slx_pkg::ST_BEGIN;
   endfunction

   function void syntax_fault();
      put(slx_pkg::KIND_ERROR, slx_pkg::CODE_NONE, 8'd0);
      lx_pending = 1'b0;
      lx_state   = slx_pkg::ST_BEGIN;
      lx_stopped = 1'b1;
   endfunction

   function bit digit_char(logic [7:0] c);
      return c >= slx_pkg::CH_ZERO && c <= slx_pkg::CH_NINE;
   endfunction

   function bit word_char(logic [7:0] c);
      return (c >= slx_pkg::CH_LOW_A && c <= slx_pkg::CH_LOW_Z) ||
             (c >= slx_pkg::CH_UPPER_A && c <= slx_pkg::CH_UPPER_Z) ||
             c == slx_pkg::CH_UNDER;
   endfunction

   function bit op_token(input logic [7:0] c, output logic [5:0] code);
      op_token = 1'b1;
      case (c)
         slx_pkg::CH_DOLLAR:   code = slx_pkg::TOK_END;
         slx_pkg::CH_COLON:    code = slx_pkg::TOK_COLON;
         slx_pkg::CH_COMMA:    code = slx_pkg::TOK_COMMA;
         slx_pkg::CH_DOT:      code = slx_pkg::TOK_DOT;
         slx_pkg::CH_LPAREN:   code = slx_pkg::TOK_LPAREN;
         slx_pkg::CH_RPAREN:   code = slx_pkg::TOK_RPAREN;
         slx_pkg::CH_LBRACKET: code = slx_pkg::TOK_LBRACKET;
         slx_pkg::CH_RBRACKET: code = slx_pkg::TOK_RBRACKET;
         slx_pkg::CH_LBRACE:   code = slx_pkg::TOK_LBRACE;
         slx_pkg::CH_RBRACE:   code = slx_pkg::TOK_RBRACE;
         slx_pkg::CH_PLUS:     code = slx_pkg::TOK_PLUS;
         slx_pkg::CH_MINUS:    code = slx_pkg::TOK_MINUS;
         slx_pkg::CH_STAR:     code = slx_pkg::TOK_STAR;
         slx_pkg::CH_SLASH:    code = slx_pkg::TOK_SLASH;
         slx_pkg::CH_PERCENT:  code = slx_pkg::TOK_PERCENT;
         slx_pkg::CH_AMP:      code = slx_pkg::TOK_AMP;
         slx_pkg::CH_PIPE:     code = slx_pkg::TOK_PIPE;
         slx_pkg::CH_CARET:    code = slx_pkg::TOK_CARET;
         slx_pkg::CH_TILDE:    code = slx_pkg::TOK_TILDE;
         default: begin
            code     = slx_pkg::CODE_NONE;
            op_token = 1'b0;
         end
      endcase
   endfunction

   function void lex_idle(logic [7:0] c);
      logic [5:0] code;
      case (c)
         slx_pkg::CH_HASH:  lx_state = slx_pkg::ST_COMMENT;
         slx_pkg::CH_AT:    lx_state = slx_pkg::ST_AT;
         slx_pkg::CH_QUOTE: lx_state = slx_pkg::ST_STR;
         slx_pkg::CH_EQ:    lx_state = slx_pkg::ST_EQ;
         slx_pkg::CH_BANG:  lx_state = slx_pkg::ST_NOT;
         slx_pkg::CH_LT:    lx_state = slx_pkg::ST_LT;
         slx_pkg::CH_GT:    lx_state = slx_pkg::ST_GT;
         default: begin
            if (op_token(c, code)) begin
               put(slx_pkg::KIND_TOKEN, code, 8'd0);
            end else if (digit_char(c)) begin
               lx_state = slx_pkg::ST_INT;
               put_value(c);
            end else if (word_char(c)) begin
               lx_state = slx_pkg::ST_WORD;
               put_value(c);
            end
         end
      endcase
   endfunction

   function void close_and_relex(logic [5:0] code, logic [7:0] c);
      close_token(code);
      lex_idle(c);
   endfunction

   function void lex_byte(logic [7:0] c);
      case (lx_state)
         slx_pkg::ST_COMMENT: if (c == slx_pkg::CH_NL) lx_state = slx_pkg::ST_BEGIN;
         slx_pkg::ST_AT: begin
            if (c == slx_pkg::CH_AT) close_token(slx_pkg::TOK_ATAT);
            else close_and_relex(slx_pkg::TOK_AT, c);
         end
         slx_pkg::ST_EQ: begin
            if (c == slx_pkg::CH_GT) close_token(slx_pkg::TOK_ARROW);
            else close_and_relex(slx_pkg::TOK_EQ, c);
         end
         slx_pkg::ST_NOT: begin
            if (c == slx_pkg::CH_EQ) close_token(slx_pkg::TOK_NE);
            else close_and_relex(slx_pkg::TOK_NOT, c);
         end
         slx_pkg::ST_LT: begin
            if (c == slx_pkg::CH_EQ) close_token(slx_pkg::TOK_LE);
            else if (c == slx_pkg::CH_LT) close_token(slx_pkg::TOK_SHL);
            else close_and_relex(slx_pkg::TOK_LT, c);
         end
         slx_pkg::ST_GT: begin
            if (c == slx_pkg::CH_EQ) close_token(slx_pkg::TOK_GE);
            else if (c == slx_pkg::CH_GT) close_token(slx_pkg::TOK_SHR);
            else close_and_relex(slx_pkg::TOK_GT, c);
         end
         slx_pkg::ST_INT: begin
            if (digit_char(c)) begin
               put_value(c);
            end else if (c == slx_pkg::CH_DOT) begin
               put_value(c);
               lx_state = slx_pkg::ST_DEC;
            end else begin
               close_and_relex(slx_pkg::TOK_INT, c);
            end
         end
         slx_pkg::ST_DEC: begin
            if (digit_char(c)) put_value(c);
            else close_and_relex(slx_pkg::TOK_DEC, c);
         end
         slx_pkg::ST_WORD: begin
            if (word_char(c)) put_value(c);
            else close_and_relex(slx_pkg::TOK_WORD, c);
         end
         slx_pkg::ST_STR: begin
            if (c == slx_pkg::CH_NL) syntax_fault();
            else if (c == slx_pkg::CH_BSL) lx_state = slx_pkg::ST_ESC;
            else if (c == slx_pkg::CH_QUOTE) close_token(slx_pkg::TOK_STR);
            else put_value(c);
         end
         slx_pkg::ST_ESC: begin
            lx_state = slx_pkg::ST_STR;
            case (c)
               slx_pkg::CH_NL:    syntax_fault();
               slx_pkg::CH_LOW_N: put_value(slx_pkg::ESC_LF);
               slx_pkg::CH_BSL:   put_value(slx_pkg::CH_BSL);
               slx_pkg::CH_QUOTE: put_value(slx_pkg::CH_QUOTE);
               slx_pkg::CH_LOW_A: put_value(slx_pkg::ESC_BEL);
               slx_pkg::CH_LOW_B: put_value(slx_pkg::ESC_BS);
               slx_pkg::CH_ZERO:  put_value(slx_pkg::CH_NUL);
               slx_pkg::CH_LOW_T: put_value(slx_pkg::ESC_TAB);
               slx_pkg::CH_LOW_R: put_value(slx_pkg::ESC_CR);
               slx_pkg::CH_LOW_F: put_value(slx_pkg::ESC_FF);
               default: begin
                  put_value(slx_pkg::CH_BSL);
                  put_value(c);
               end
            endcase
         end
         default: begin
            lx_state = slx_pkg::ST_BEGIN;
            lex_idle(c);
         end
      endcase
   endfunction

   // Returns 1 when the byte reaches the lexer instead of falling on a stopped line.
   function bit lex_predict(logic [7:0] c, logic ls);
      bit live;
      step_count = 0;
      if (ls) begin
         if (lx_pending) put(slx_pkg::KIND_ABANDON, slx_pkg::CODE_NONE, 8'd0);
         lx_state   = slx_pkg::ST_BEGIN;
         lx_pending = 1'b0;
         lx_stopped = 1'b0;
      end
      live = !lx_stopped;
      if (!lx_stopped) begin
         if (c == slx_pkg::CH_NUL) lx_stopped = 1'b1;
         else lex_byte(c);
      end
      if (step_count > 0) step_res[step_count - 1].last = 1'b1;
      for (int i = 0; i < step_count; i++) due_results.insert(due_results.size(), step_res[i]);
      return live;
   endfunction

   task automatic send_byte(input logic [7:0] c, input logic ls);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_char_in    <= c;
      req_line_start <= ls;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      if (lex_predict(c, ls)) live_bytes++;
   endtask

   task automatic send_text(input string s, input bit ls_first);
      int i;
      for (i = 0; i < s.len(); i++) send_byte(s[i], ls_first && i == 0);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function logic [7:0] pick(string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   function void add_byte(logic [7:0] c, logic ls = 1'b0);
      line_q.insert(line_q.size(), {ls, c});
   endfunction

   function void build_line();
      int n, k, j, len;
      line_q.delete();
      n = $urandom_range(1, 8);
      for (k = 0; k < n; k++) begin
         case ($urandom_range(0, 11))
            0, 1: add_byte(pick(":,.()[]{}+-*/%&|^~$"));
            2: begin
               add_byte(pick("@=!<>"));
               if ($urandom_range(0, 2) != 0) add_byte(pick("@>=<!x1 ("));
            end
            3: begin
               len = $urandom_range(1, 4);
               for (j = 0; j < len; j++) add_byte(pick("0123456789"));
            end
            4: begin
               add_byte(pick("0123456789"));
               add_byte(slx_pkg::CH_DOT);
               len = $urandom_range(0, 3);
               for (j = 0; j < len; j++) add_byte(pick("0123456789"));
            end
            5: begin
               len = $urandom_range(1, 6);
               for (j = 0; j < len; j++) add_byte(pick("abmzAMZ_q"));
            end
            6: begin
               add_byte(slx_pkg::CH_QUOTE);
               len = $urandom_range(0, 6);
               for (j = 0; j < len; j++) begin
                  case ($urandom_range(0, 9))
                     0, 1, 2, 3, 4: add_byte(8'($urandom_range(32, 126)));
                     5: add_byte(8'($urandom_range(128, 255)));
                     6, 7: begin
                        add_byte(slx_pkg::CH_BSL);
                        add_byte(pick("nrtabf0\\\"qZ"));
                     end
                     default: begin
                        add_byte(slx_pkg::CH_BSL);
                        add_byte(8'($urandom_range(1, 255)));
                     end
                  endcase
               end
               case ($urandom_range(0, 19))
                  0: add_byte(slx_pkg::CH_NL);
                  1: begin
                     add_byte(slx_pkg::CH_BSL);
                     add_byte(slx_pkg::CH_NL);
                  end
                  2: ;
                  default: add_byte(slx_pkg::CH_QUOTE);
               endcase
            end
            7: begin
               add_byte(slx_pkg::CH_HASH);
               len = $urandom_range(0, 5);
               for (j = 0; j < len; j++) add_byte(8'($urandom_range(1, 255)));
               add_byte(slx_pkg::CH_NL);
            end
            8: add_byte(pick(" \t\n"));
            9: add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            10: begin
               if ($urandom_range(0, 3) == 0) add_byte(slx_pkg::CH_NUL);
               else add_byte(pick(" \n"));
            end
            default: add_byte(slx_pkg::CH_DOLLAR);
         endcase
      end
      line_q[0][8] = 1'b1;
   endfunction

   task automatic test_operators();
      send_text("=>!=<x@@=+", 1'b1);
   endtask

   task automatic test_numbers();
      send_text("7.25$", 1'b1);
   endtask

   task automatic test_strings();
      send_byte(slx_pkg::CH_QUOTE, 1'b1);
      send_text("\\q\\r", 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text("\"\"a\n", 1'b0);
      send_text("\"\\\n", 1'b1);
   endtask

   task automatic test_line_control();
      send_text("ab", 1'b1);
      send_byte(slx_pkg::CH_NUL, 1'b0);
      send_text("c", 1'b0);
      send_text("#$\n~", 1'b1);
   endtask

   task automatic test_random_lines(input int send_pct, input int stall_pct, input int goal);
      int start;
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      start          = bytes_sent;
      while (bytes_sent - start < goal) begin
         build_line();
         foreach (line_q[i]) send_byte(line_q[i][7:0], line_q[i][8]);
      end
      wait_drained();
   endtask

   always @(negedge clock) begin
      rsp_stall <= $urandom_range(0, 99) < recv_stall_pct;
   end

   always @(posedge clock) begin : check_rsp
      lex_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         kind_seen[rsp_kind]++;
         if (due_results.size() == 0) begin
            $error("unexpected result: kind %0d code %0d byte %0d last %0d",
                   rsp_kind, rsp_token_code, rsp_value_byte, rsp_last);
            fail_count++;
         end else begin
            want = due_results.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               fail_count++;
            end
            if (rsp_token_code !== want.code) begin
               $error("token_code: expected %0d, got %0d", want.code, rsp_token_code);
               fail_count++;
            end
            if (rsp_value_byte !== want.vbyte) begin
               $error("value_byte: expected %0d, got %0d", want.vbyte, rsp_value_byte);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("script_lexer_byte_stream: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_operators();
      test_numbers();
      test_strings();
      test_line_control();
      wait_drained();

      test_random_lines(0, 0, 370);
      test_random_lines(82, 0, 370);
      test_random_lines(0, 82, 370);
      test_random_lines(25, 25, 370);

      if (due_results.size() != 0) begin
         $error("%0d expected results never arrived", due_results.size());
         fail_count++;
      end
      $display("Fed %0d source bytes (%0d reached the lexer) under four handshake phases.",
               bytes_sent, live_bytes);
      $display("Checked %0d value bytes, %0d tokens, %0d syntax errors, %0d abandoned values.",
               kind_seen[slx_pkg::KIND_VALUE], kind_seen[slx_pkg::KIND_TOKEN],
               kind_seen[slx_pkg::KIND_ERROR], kind_seen[slx_pkg::KIND_ABANDON]);
      if (fail_count == 0) begin
         $display("script_lexer_byte_stream: match");
      end else begin
         $display("script_lexer_byte_stream: mismatch");
      end
      $finish;
   end

endmodule

// ----- script_lexer_byte_stream.f -----
rtl/slx_pkg.sv
rtl/slx_front.sv
rtl/slx_queue.sv
rtl/slx_back.sv
rtl/script_lexer_byte_stream.sv
tb/tb.sv
